>>> rtl/core/pvbl_pkg.sv
// Shared types, codes and default sizes of the polyline bounds and length block.
`timescale 1ns / 1ps
`default_nettype none

package pvbl_pkg;

    localparam int COORD_WIDTH_DEF  = 32;
    localparam int LENGTH_WIDTH_DEF = 48;
    localparam int THR_WIDTH        = 31;
    localparam int STATUS_WIDTH     = 3;
    localparam int REQ_WIDTH        = 2;

    localparam logic [THR_WIDTH-1:0] THR_RESET = THR_WIDTH'(1);

    typedef enum logic [REQ_WIDTH-1:0] {
        REQ_START = 2'd0,
        REQ_ADD   = 2'd1,
        REQ_CLEAR = 2'd2
    } req_code_t;

    typedef enum logic [STATUS_WIDTH-1:0] {
        ST_APPENDED   = 3'd0,
        ST_DUPLICATE  = 3'd1,
        ST_NO_POLYGON = 3'd2,
        ST_STARTED    = 3'd3,
        ST_CLEARED    = 3'd4
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIFF,
        S_CHECK,
        S_SQX,
        S_SQY,
        S_LAUNCH,
        S_ROOT,
        S_ACC,
        S_DONE
    } state_t;

    typedef struct packed {
        logic clear;
        logic load;
    } box_ctrl_t;

endpackage

`default_nettype wire

>>> rtl/core/pvbl_if.sv
// Channel interfaces: request stream, result stream and threshold write port.
`timescale 1ns / 1ps
`default_nettype none

interface pvbl_req_if #(
    parameter int COORD_WIDTH = pvbl_pkg::COORD_WIDTH_DEF
);
    logic                                 valid;
    logic                                 ready;
    logic [pvbl_pkg::REQ_WIDTH-1:0]       req_type;
    logic signed [COORD_WIDTH-1:0]        coord_x;
    logic signed [COORD_WIDTH-1:0]        coord_y;

    modport source (output valid, req_type, coord_x, coord_y, input ready);
    modport sink (input valid, req_type, coord_x, coord_y, output ready);
endinterface

interface pvbl_rsp_if #(
    parameter int COORD_WIDTH  = pvbl_pkg::COORD_WIDTH_DEF,
    parameter int LENGTH_WIDTH = pvbl_pkg::LENGTH_WIDTH_DEF
);
    logic                                 valid;
    logic                                 ready;
    logic [pvbl_pkg::STATUS_WIDTH-1:0]    status;
    logic                                 bounds_valid;
    logic signed [COORD_WIDTH-1:0]        box_left;
    logic signed [COORD_WIDTH-1:0]        box_bottom;
    logic signed [COORD_WIDTH-1:0]        box_right;
    logic signed [COORD_WIDTH-1:0]        box_top;
    logic [LENGTH_WIDTH-1:0]              total_length;
    logic                                 length_saturated;

    modport source (
        output valid, status, bounds_valid, box_left, box_bottom, box_right, box_top,
               total_length, length_saturated,
        input  ready
    );
    modport sink (
        input  valid, status, bounds_valid, box_left, box_bottom, box_right, box_top,
               total_length, length_saturated,
        output ready
    );
endinterface

interface pvbl_cfg_if;
    logic                                 valid;
    logic                                 ready;
    logic [pvbl_pkg::THR_WIDTH-1:0]       dup_threshold;

    modport source (output valid, dup_threshold, input ready);
    modport sink (input valid, dup_threshold, output ready);
endinterface

`default_nettype wire

>>> rtl/core/pvbl_sqrt.sv
// Iterative bit-pair restoring square root, one root bit per cycle.
`timescale 1ns / 1ps
`default_nettype none

module pvbl_sqrt #(
    parameter int ROOT_WIDTH = pvbl_pkg::COORD_WIDTH_DEF + 1
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    input  wire logic [2*ROOT_WIDTH-1:0]   radicand,
    output logic                           busy,
    output logic                           done,
    output logic [ROOT_WIDTH-1:0]          root
);

    localparam int RAD_WIDTH = 2 * ROOT_WIDTH;
    localparam int CNT_WIDTH = $clog2(ROOT_WIDTH + 1);
    localparam int CAND_WIDTH = ROOT_WIDTH + 3;

    logic                  busy_reg;
    logic                  busy_next;
    logic                  done_reg;
    logic                  done_next;
    logic [CNT_WIDTH-1:0]  cnt_reg;
    logic [CNT_WIDTH-1:0]  cnt_next;
    logic [RAD_WIDTH-1:0]  rad_reg;
    logic [ROOT_WIDTH:0]   rem_reg;
    logic [ROOT_WIDTH-1:0] root_reg;

    logic [CAND_WIDTH-1:0] cand;
    logic [CAND_WIDTH-1:0] trial;
    logic [CAND_WIDTH-1:0] diff;
    logic                  take;

    // The remainder never exceeds twice the partial root, so it fits one bit above the root.
    assign cand  = {rem_reg, rad_reg[RAD_WIDTH-1 -: 2]};
    assign trial = CAND_WIDTH'({root_reg, 2'b01});
    assign take  = cand >= trial;
    assign diff  = cand - trial;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_WIDTH'(ROOT_WIDTH);
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg - CNT_WIDTH'(1);
            if (cnt_reg == CNT_WIDTH'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rad_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            rad_reg  <= {rad_reg[RAD_WIDTH-3:0], 2'b00};
            rem_reg  <= take ? diff[ROOT_WIDTH:0] : cand[ROOT_WIDTH:0];
            root_reg <= {root_reg[ROOT_WIDTH-2:0], take};
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign root = root_reg;

`ifndef NO_ASSERTIONS
    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg)
        else $error("square root done while still iterating");
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> busy_reg)
        else $error("square root did not start");
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(busy_reg))
        else $error("square root done without iterations");
`endif

endmodule

`default_nettype wire

>>> rtl/core/pvbl_box.sv
// Bounding box register bank of the accepted vertices.
`timescale 1ns / 1ps
`default_nettype none

module pvbl_box #(
    parameter int COORD_WIDTH = pvbl_pkg::COORD_WIDTH_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire pvbl_pkg::box_ctrl_t           ctrl,
    input  wire logic signed [COORD_WIDTH-1:0] x,
    input  wire logic signed [COORD_WIDTH-1:0] y,
    output logic                               held,
    output logic signed [COORD_WIDTH-1:0]      left,
    output logic signed [COORD_WIDTH-1:0]      bottom,
    output logic signed [COORD_WIDTH-1:0]      right,
    output logic signed [COORD_WIDTH-1:0]      top
);

    logic                          held_reg;
    logic                          held_next;
    logic signed [COORD_WIDTH-1:0] left_reg;
    logic signed [COORD_WIDTH-1:0] bottom_reg;
    logic signed [COORD_WIDTH-1:0] right_reg;
    logic signed [COORD_WIDTH-1:0] top_reg;

    always_comb
    begin
        held_next = held_reg;
        if (ctrl.clear)
            held_next = 1'b0;
        else if (ctrl.load)
            held_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            held_reg <= 1'b0;
        else
            held_reg <= held_next;
    end

    // A vertex loaded while no box is held (after reset or a clear) seeds the left, bottom, right and top edges.
    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            if (!held_reg || x < left_reg)
                left_reg <= x;
            if (!held_reg || y < bottom_reg)
                bottom_reg <= y;
            if (!held_reg || x > right_reg)
                right_reg <= x;
            if (!held_reg || y > top_reg)
                top_reg <= y;
        end
    end

    assign held   = held_reg;
    assign left   = held_reg ? left_reg : '0;
    assign bottom = held_reg ? bottom_reg : '0;
    assign right  = held_reg ? right_reg : '0;
    assign top    = held_reg ? top_reg : '0;

`ifndef NO_ASSERTIONS
    a_ordered_x: assert property (@(posedge clk) disable iff (!rst_n)
        held_reg |-> left_reg <= right_reg)
        else $error("box left edge beyond right edge");
    a_ordered_y: assert property (@(posedge clk) disable iff (!rst_n)
        held_reg |-> bottom_reg <= top_reg)
        else $error("box bottom edge above top edge");
    a_load_holds: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.load && !ctrl.clear |=> held_reg)
        else $error("box not held after a vertex load");
`endif

endmodule

`default_nettype wire

>>> rtl/core/polyline_vertex_bounds_length_top.sv
// Top level: request sequencer, segment length datapath and result register.
`timescale 1ns / 1ps
`default_nettype none

// Polyline bounds and length collector. Every request gives one result transaction.
// An accepted request holds the sequencer until its DONE state, where the result
// register loads. Start, clear and reserved requests, and an add that finds no open
// polygon, go straight to DONE; the first vertex of a polygon passes through ACC. A
// vertex that follows another in its polygon takes the difference and threshold
// check (DIFF, CHECK) and goes to DONE when it is dropped as a near-duplicate; else
// one multiplier squares dx and then dy, a launch state starts the square root unit,
// which works out the COORD_WIDTH + 1 root bits one by one and then flags completion,
// and then the length is accumulated. A result that finds the previous one still
// waiting for the receiver holds the sequencer in DONE. One request is in work at a
// time; the next one is taken while the previous result still waits in the output
// register. The threshold port is always ready and should only be written while no
// request is in work.
module polyline_vertex_bounds_length_top #(
    parameter int COORD_WIDTH  = pvbl_pkg::COORD_WIDTH_DEF,
    parameter int LENGTH_WIDTH = pvbl_pkg::LENGTH_WIDTH_DEF
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    pvbl_cfg_if.sink    cfg,
    pvbl_req_if.sink    req,
    pvbl_rsp_if.source  rsp
);

    localparam int MAG_WIDTH = COORD_WIDTH + 1;
    localparam int SQ_WIDTH  = 2 * MAG_WIDTH;
    localparam int CMP_WIDTH = (MAG_WIDTH > pvbl_pkg::THR_WIDTH) ? MAG_WIDTH
                                                                 : pvbl_pkg::THR_WIDTH;
    localparam logic [LENGTH_WIDTH-1:0] LENGTH_MAX = '1;

    pvbl_pkg::state_t                   state_reg;
    pvbl_pkg::state_t                   state_next;
    logic                               polygon_open_reg;
    logic                               polygon_open_next;
    logic                               prev_valid_reg;
    logic                               prev_valid_next;
    logic [LENGTH_WIDTH-1:0]            length_reg;
    logic [LENGTH_WIDTH-1:0]            length_next;
    logic                               sat_reg;
    logic                               sat_next;
    logic [pvbl_pkg::THR_WIDTH-1:0]     thr_reg;
    logic [pvbl_pkg::THR_WIDTH-1:0]     thr_next;
    logic                               rsp_valid_reg;
    logic                               rsp_valid_next;
    pvbl_pkg::status_t                  status_reg;
    pvbl_pkg::status_t                  status_next;

    logic signed [COORD_WIDTH-1:0]      x_reg;
    logic signed [COORD_WIDTH-1:0]      y_reg;
    logic signed [COORD_WIDTH-1:0]      prev_x_reg;
    logic signed [COORD_WIDTH-1:0]      prev_y_reg;
    logic signed [MAG_WIDTH-1:0]        dx_reg;
    logic signed [MAG_WIDTH-1:0]        dy_reg;
    logic [MAG_WIDTH-1:0]               ax_reg;
    logic [MAG_WIDTH-1:0]               ay_reg;
    logic [SQ_WIDTH-1:0]                sqx_reg;
    logic [SQ_WIDTH-1:0]                rad_reg;

    logic [pvbl_pkg::STATUS_WIDTH-1:0]  out_status_reg;
    logic                               out_held_reg;
    logic signed [COORD_WIDTH-1:0]      out_left_reg;
    logic signed [COORD_WIDTH-1:0]      out_bottom_reg;
    logic signed [COORD_WIDTH-1:0]      out_right_reg;
    logic signed [COORD_WIDTH-1:0]      out_top_reg;
    logic [LENGTH_WIDTH-1:0]            out_length_reg;
    logic                               out_sat_reg;

    logic                               capture;
    logic                               out_load;
    logic                               prev_load;
    pvbl_pkg::box_ctrl_t                box_ctrl;
    logic                               box_held;
    logic signed [COORD_WIDTH-1:0]      box_left;
    logic signed [COORD_WIDTH-1:0]      box_bottom;
    logic signed [COORD_WIDTH-1:0]      box_right;
    logic signed [COORD_WIDTH-1:0]      box_top;

    logic [MAG_WIDTH-1:0]               ax_now;
    logic [MAG_WIDTH-1:0]               ay_now;
    logic                               is_dup;
    logic [MAG_WIDTH-1:0]               mul_a;
    logic [SQ_WIDTH-1:0]                prod;
    logic [LENGTH_WIDTH:0]              len_sum;

    logic                               sq_start;
    logic                               sq_busy;
    logic                               sq_done;
    logic [MAG_WIDTH-1:0]               sq_root;

    assign ax_now = dx_reg[MAG_WIDTH-1] ? MAG_WIDTH'(-dx_reg) : MAG_WIDTH'(dx_reg);
    assign ay_now = dy_reg[MAG_WIDTH-1] ? MAG_WIDTH'(-dy_reg) : MAG_WIDTH'(dy_reg);
    assign is_dup = (CMP_WIDTH'(ax_now) < CMP_WIDTH'(thr_reg))
                 && (CMP_WIDTH'(ay_now) < CMP_WIDTH'(thr_reg));

    // One multiplier squares dx in state SQX and dy in state SQY.
    assign mul_a   = (state_reg == pvbl_pkg::S_SQY) ? ay_reg : ax_reg;
    assign prod    = SQ_WIDTH'(mul_a) * SQ_WIDTH'(mul_a);
    assign len_sum = {1'b0, length_reg} + (LENGTH_WIDTH + 1)'(sq_root);

    always_comb
    begin
        state_next        = state_reg;
        polygon_open_next = polygon_open_reg;
        prev_valid_next   = prev_valid_reg;
        length_next       = length_reg;
        sat_next          = sat_reg;
        thr_next          = thr_reg;
        status_next       = status_reg;
        rsp_valid_next    = rsp_valid_reg && !rsp.ready;
        capture           = 1'b0;
        out_load          = 1'b0;
        prev_load         = 1'b0;
        box_ctrl          = '0;
        sq_start          = 1'b0;

        if (cfg.valid)
            thr_next = cfg.dup_threshold;

        unique case (state_reg)
            pvbl_pkg::S_IDLE:
            begin
                if (req.valid)
                begin
                    capture = 1'b1;
                    unique case (req.req_type)
                        pvbl_pkg::REQ_START:
                        begin
                            polygon_open_next = 1'b1;
                            prev_valid_next   = 1'b0;
                            status_next       = pvbl_pkg::ST_STARTED;
                            state_next        = pvbl_pkg::S_DONE;
                        end
                        pvbl_pkg::REQ_ADD:
                        begin
                            if (!polygon_open_reg)
                            begin
                                status_next = pvbl_pkg::ST_NO_POLYGON;
                                state_next  = pvbl_pkg::S_DONE;
                            end
                            else if (prev_valid_reg)
                                state_next = pvbl_pkg::S_DIFF;
                            else
                                state_next = pvbl_pkg::S_ACC;
                        end
                        pvbl_pkg::REQ_CLEAR:
                        begin
                            polygon_open_next = 1'b0;
                            prev_valid_next   = 1'b0;
                            box_ctrl.clear    = 1'b1;
                            length_next       = '0;
                            sat_next          = 1'b0;
                            status_next       = pvbl_pkg::ST_CLEARED;
                            state_next        = pvbl_pkg::S_DONE;
                        end
                        default:
                        begin
                            status_next = pvbl_pkg::ST_DUPLICATE;
                            state_next  = pvbl_pkg::S_DONE;
                        end
                    endcase
                end
            end
            pvbl_pkg::S_DIFF:
                state_next = pvbl_pkg::S_CHECK;
            pvbl_pkg::S_CHECK:
            begin
                if (is_dup)
                begin
                    status_next = pvbl_pkg::ST_DUPLICATE;
                    state_next  = pvbl_pkg::S_DONE;
                end
                else
                    state_next = pvbl_pkg::S_SQX;
            end
            pvbl_pkg::S_SQX:
                state_next = pvbl_pkg::S_SQY;
            pvbl_pkg::S_SQY:
                state_next = pvbl_pkg::S_LAUNCH;
            pvbl_pkg::S_LAUNCH:
            begin
                sq_start   = 1'b1;
                state_next = pvbl_pkg::S_ROOT;
            end
            pvbl_pkg::S_ROOT:
            begin
                if (sq_done)
                    state_next = pvbl_pkg::S_ACC;
            end
            pvbl_pkg::S_ACC:
            begin
                // Only a vertex with a predecessor in its polygon closes a segment.
                if (prev_valid_reg)
                begin
                    if (len_sum[LENGTH_WIDTH])
                    begin
                        length_next = LENGTH_MAX;
                        sat_next    = 1'b1;
                    end
                    else
                        length_next = len_sum[LENGTH_WIDTH-1:0];
                end
                box_ctrl.load   = 1'b1;
                prev_load       = 1'b1;
                prev_valid_next = 1'b1;
                status_next     = pvbl_pkg::ST_APPENDED;
                state_next      = pvbl_pkg::S_DONE;
            end
            pvbl_pkg::S_DONE:
            begin
                if (!rsp_valid_reg || rsp.ready)
                begin
                    out_load       = 1'b1;
                    rsp_valid_next = 1'b1;
                    state_next     = pvbl_pkg::S_IDLE;
                end
            end
            default:
                state_next = pvbl_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= pvbl_pkg::S_IDLE;
            polygon_open_reg <= 1'b0;
            prev_valid_reg   <= 1'b0;
            length_reg       <= '0;
            sat_reg          <= 1'b0;
            thr_reg          <= pvbl_pkg::THR_RESET;
            rsp_valid_reg    <= 1'b0;
            status_reg       <= pvbl_pkg::ST_APPENDED;
        end
        else
        begin
            state_reg        <= state_next;
            polygon_open_reg <= polygon_open_next;
            prev_valid_reg   <= prev_valid_next;
            length_reg       <= length_next;
            sat_reg          <= sat_next;
            thr_reg          <= thr_next;
            rsp_valid_reg    <= rsp_valid_next;
            status_reg       <= status_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (capture)
        begin
            x_reg <= req.coord_x;
            y_reg <= req.coord_y;
        end
        if (prev_load)
        begin
            prev_x_reg <= x_reg;
            prev_y_reg <= y_reg;
        end
        if (state_reg == pvbl_pkg::S_DIFF)
        begin
            dx_reg <= MAG_WIDTH'(x_reg) - MAG_WIDTH'(prev_x_reg);
            dy_reg <= MAG_WIDTH'(y_reg) - MAG_WIDTH'(prev_y_reg);
        end
        if (state_reg == pvbl_pkg::S_CHECK)
        begin
            ax_reg <= ax_now;
            ay_reg <= ay_now;
        end
        if (state_reg == pvbl_pkg::S_SQX)
            sqx_reg <= prod;
        if (state_reg == pvbl_pkg::S_SQY)
            rad_reg <= sqx_reg + prod;
        if (out_load)
        begin
            out_status_reg <= status_reg;
            out_held_reg   <= box_held;
            out_left_reg   <= box_left;
            out_bottom_reg <= box_bottom;
            out_right_reg  <= box_right;
            out_top_reg    <= box_top;
            out_length_reg <= length_reg;
            out_sat_reg    <= sat_reg;
        end
    end

    pvbl_box #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_box (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (box_ctrl),
        .x      (x_reg),
        .y      (y_reg),
        .held   (box_held),
        .left   (box_left),
        .bottom (box_bottom),
        .right  (box_right),
        .top    (box_top)
    );

    pvbl_sqrt #(
        .ROOT_WIDTH (MAG_WIDTH)
    ) u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sq_start),
        .radicand (rad_reg),
        .busy     (sq_busy),
        .done     (sq_done),
        .root     (sq_root)
    );

    assign cfg.ready = 1'b1;
    assign req.ready = (state_reg == pvbl_pkg::S_IDLE);

    assign rsp.valid            = rsp_valid_reg;
    assign rsp.status           = out_status_reg;
    assign rsp.bounds_valid     = out_held_reg;
    assign rsp.box_left         = out_left_reg;
    assign rsp.box_bottom       = out_bottom_reg;
    assign rsp.box_right        = out_right_reg;
    assign rsp.box_top          = out_top_reg;
    assign rsp.total_length     = out_length_reg;
    assign rsp.length_saturated = out_sat_reg;

`ifndef NO_ASSERTIONS
    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        req.valid && req.ready |=> state_reg != pvbl_pkg::S_IDLE)
        else $error("accepted request left the sequencer idle");
    a_sat_at_max: assert property (@(posedge clk) disable iff (!rst_n)
        sat_reg |-> length_reg == LENGTH_MAX)
        else $error("saturation flag set below the maximum length");
    a_prev_needs_polygon: assert property (@(posedge clk) disable iff (!rst_n)
        prev_valid_reg |-> polygon_open_reg)
        else $error("previous vertex held without an open polygon");
    a_root_only_when_waiting: assert property (@(posedge clk) disable iff (!rst_n)
        sq_busy |-> state_reg == pvbl_pkg::S_ROOT)
        else $error("square root running outside its wait state");
`endif

endmodule

`default_nettype wire

>>> tb/tb.sv
// Self-checking testbench for the polyline bounds and arc length block.
`timescale 1ns / 1ps

module tb;
    import pvbl_pkg::*;

    localparam int CW = COORD_WIDTH_DEF;
    localparam int LW = LENGTH_WIDTH_DEF;
    localparam logic [REQ_WIDTH-1:0] REQ_RESERVED = 2'd3;
    localparam logic signed [CW-1:0] COORD_MIN = {1'b1, {(CW-1){1'b0}}};
    localparam logic signed [CW-1:0] COORD_MAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic [THR_WIDTH-1:0] THR_MAX = '1;
    localparam int SETTLE_CYCLES = 50;
    localparam int CYCLE_LIMIT = 1000000;

    typedef enum logic [1:0] {
        PH_FREE,
        PH_SEND,
        PH_RECV,
        PH_BOTH
    } idle_phase_t;

    typedef struct {
        logic [REQ_WIDTH-1:0]  code;
        logic signed [CW-1:0]  x;
        logic signed [CW-1:0]  y;
    } path_request_t;

    typedef struct {
        status_t               status;
        logic                  bounds_valid;
        logic signed [CW-1:0]  left;
        logic signed [CW-1:0]  bottom;
        logic signed [CW-1:0]  right;
        logic signed [CW-1:0]  top;
        logic [LW-1:0]         length;
        logic                  saturated;
    } path_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                  req_valid_q = 1'b0;
    logic [REQ_WIDTH-1:0]  req_type_q = REQ_START;
    logic signed [CW-1:0]  req_x_q = '0;
    logic signed [CW-1:0]  req_y_q = '0;
    logic                  rsp_ready_q = 1'b0;
    logic                  cfg_valid_q = 1'b0;
    logic [THR_WIDTH-1:0]  cfg_thr_q = '0;

    pvbl_cfg_if cfg_bus ();
    pvbl_req_if #(.COORD_WIDTH(CW)) req_bus ();
    pvbl_rsp_if #(.COORD_WIDTH(CW), .LENGTH_WIDTH(LW)) rsp_bus ();

    assign cfg_bus.valid = cfg_valid_q;
    assign cfg_bus.dup_threshold = cfg_thr_q;
    assign req_bus.valid = req_valid_q;
    assign req_bus.req_type = req_type_q;
    assign req_bus.coord_x = req_x_q;
    assign req_bus.coord_y = req_y_q;
    assign rsp_bus.ready = rsp_ready_q;

    polyline_vertex_bounds_length_top #(
        .COORD_WIDTH(CW),
        .LENGTH_WIDTH(LW)
    ) u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg(cfg_bus),
        .req(req_bus),
        .rsp(rsp_bus)
    );

    // Shadow copy of the figure state.
    logic                  poly_open = 1'b0;
    logic                  prev_held = 1'b0;
    logic signed [CW-1:0]  prev_x = '0;
    logic signed [CW-1:0]  prev_y = '0;
    logic                  box_held = 1'b0;
    logic signed [CW-1:0]  box_l = '0;
    logic signed [CW-1:0]  box_b = '0;
    logic signed [CW-1:0]  box_r = '0;
    logic signed [CW-1:0]  box_t = '0;
    logic [LW-1:0]         len_sum = '0;
    logic                  len_sat = 1'b0;
    logic [THR_WIDTH-1:0]  dup_thr = THR_RESET;

    path_request_t  pending_requests[$];
    path_result_t   expected_results[$];
    path_request_t  next_req;
    path_result_t   want;
    idle_phase_t    phase = PH_FREE;
    logic signed [CW-1:0] last_x = '0;
    logic signed [CW-1:0] last_y = '0;
    int issued_cnt = 0;
    int checked_cnt = 0;
    int err_cnt = 0;
    int cycle_cnt = 0;

    initial
    begin
        forever #6 clk = ~clk;
    end

    function automatic logic [CW:0] floor_root(logic [2*CW+1:0] n);
        logic [CW:0] r;
        logic [CW:0] c;
        logic [2*CW+1:0] wc;
        r = '0;
        for (int b = CW; b >= 0; b--)
        begin
            c = r;
            c[b] = 1'b1;
            wc = {{(CW+1){1'b0}}, c};
            if (wc * wc <= n)
                r = c;
        end
        return r;
    endfunction

    // Applies one accepted request to the shadow state and returns its result.
    function automatic path_result_t apply_request(logic [REQ_WIDTH-1:0] code,
                                                   logic signed [CW-1:0] x,
                                                   logic signed [CW-1:0] y);
        path_result_t r;
        logic signed [CW:0] dx;
        logic signed [CW:0] dy;
        logic [CW:0] ax;
        logic [CW:0] ay;
        logic [2*CW+1:0] wx;
        logic [2*CW+1:0] wy;
        logic [LW-1:0] seg;
        logic [LW-1:0] len_max;
        len_max = '1;
        case (code)
            REQ_START:
            begin
                poly_open = 1'b1;
                prev_held = 1'b0;
                r.status = ST_STARTED;
            end
            REQ_ADD:
            begin
                dx = {x[CW-1], x} - {prev_x[CW-1], prev_x};
                dy = {y[CW-1], y} - {prev_y[CW-1], prev_y};
                ax = dx[CW] ? ~dx + 1'b1 : dx;
                ay = dy[CW] ? ~dy + 1'b1 : dy;
                if (!poly_open)
                begin
                    r.status = ST_NO_POLYGON;
                end
                else if (prev_held && ax < dup_thr && ay < dup_thr)
                begin
                    r.status = ST_DUPLICATE;
                end
                else
                begin
                    if (prev_held)
                    begin
                        wx = ax;
                        wy = ay;
                        seg = LW'(floor_root(wx * wx + wy * wy));
                        if (len_sum > len_max - seg)
                        begin
                            len_sum = len_max;
                            len_sat = 1'b1;
                        end
                        else
                        begin
                            len_sum = len_sum + seg;
                        end
                    end
                    if (!box_held)
                    begin
                        box_l = x;
                        box_r = x;
                        box_b = y;
                        box_t = y;
                        box_held = 1'b1;
                    end
                    else
                    begin
                        if (x < box_l) box_l = x;
                        if (y < box_b) box_b = y;
                        if (x > box_r) box_r = x;
                        if (y > box_t) box_t = y;
                    end
                    prev_x = x;
                    prev_y = y;
                    prev_held = 1'b1;
                    r.status = ST_APPENDED;
                end
            end
            REQ_CLEAR:
            begin
                poly_open = 1'b0;
                prev_held = 1'b0;
                box_held = 1'b0;
                box_l = '0;
                box_b = '0;
                box_r = '0;
                box_t = '0;
                len_sum = '0;
                len_sat = 1'b0;
                r.status = ST_CLEARED;
            end
            default:
            begin
                r.status = ST_DUPLICATE;
            end
        endcase
        r.bounds_valid = box_held;
        r.left = box_held ? box_l : '0;
        r.bottom = box_held ? box_b : '0;
        r.right = box_held ? box_r : '0;
        r.top = box_held ? box_t : '0;
        r.length = len_sum;
        r.saturated = len_sat;
        return r;
    endfunction

    function automatic bit sender_idles();
        return (phase == PH_SEND && $urandom_range(99) < 62) ||
               (phase == PH_BOTH && $urandom_range(99) < 17);
    endfunction

    function automatic bit receiver_stalls();
        return (phase == PH_RECV && $urandom_range(99) < 62) ||
               (phase == PH_BOTH && $urandom_range(99) < 17);
    endfunction

    // Request driver: the shadow state advances at the edge that accepts a transaction.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_q <= 1'b0;
        end
        else if (!req_valid_q || req_bus.ready)
        begin
            if (req_valid_q)
                expected_results.push_back(apply_request(req_type_q, req_x_q, req_y_q));
            if (pending_requests.size() != 0 && !sender_idles())
            begin
                next_req = pending_requests.pop_front();
                req_valid_q <= 1'b1;
                req_type_q <= next_req.code;
                req_x_q <= next_req.x;
                req_y_q <= next_req.y;
            end
            else
            begin
                req_valid_q <= 1'b0;
            end
        end
    end

    task automatic check_field(string name, logic [63:0] exp_val, logic [63:0] act_val);
        if (exp_val !== act_val)
        begin
            $display("%0t ns: %s mismatch, expected %h, actual %h",
                     $time, name, exp_val, act_val);
            err_cnt++;
        end
    endtask

    // Result monitor.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_ready_q <= 1'b0;
        end
        else
        begin
            if (rsp_bus.valid && rsp_ready_q)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t ns: result transaction with nothing expected, status %h",
                             $time, rsp_bus.status);
                    err_cnt++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("status", want.status, rsp_bus.status);
                    check_field("bounds_valid", want.bounds_valid, rsp_bus.bounds_valid);
                    check_field("box_left", want.left, rsp_bus.box_left);
                    check_field("box_bottom", want.bottom, rsp_bus.box_bottom);
                    check_field("box_right", want.right, rsp_bus.box_right);
                    check_field("box_top", want.top, rsp_bus.box_top);
                    check_field("total_length", want.length, rsp_bus.total_length);
                    check_field("length_saturated", want.saturated,
                                rsp_bus.length_saturated);
                    checked_cnt++;
                end
            end
            rsp_ready_q <= !receiver_stalls();
        end
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic queue_request(logic [REQ_WIDTH-1:0] code, logic signed [CW-1:0] x,
                                 logic signed [CW-1:0] y);
        path_request_t item;
        item.code = code;
        item.x = x;
        item.y = y;
        pending_requests.push_back(item);
        issued_cnt++;
        if (code == REQ_ADD)
        begin
            last_x = x;
            last_y = y;
        end
    endtask

    // Mix of full-range, extreme, small and near-previous coordinates.
    function automatic logic signed [CW-1:0] pick_coord(logic signed [CW-1:0] base);
        longint span;
        longint offs;
        case ($urandom_range(9))
            0, 1: return CW'($urandom);
            2:
            begin
                case ($urandom_range(4))
                    0: return COORD_MIN;
                    1: return COORD_MAX;
                    2: return '0;
                    3: return '1;
                    default: return CW'(1);
                endcase
            end
            3, 4, 5: return CW'(int'($urandom_range(0, 2097152)) - 1048576);
            default:
            begin
                span = (dup_thr > 31'h3FFF_FFFF) ? 64'sd1073741824 : longint'(dup_thr) + 2;
                offs = longint'($urandom_range(0, 32'(2 * span))) - span;
                return CW'(longint'(base) + offs);
            end
        endcase
    endfunction

    task automatic load_random(int n);
        int cnt;
        int m;
        cnt = 0;
        while (cnt < n)
        begin
            if ($urandom_range(99) < 80)
            begin
                queue_request(REQ_START, CW'($urandom), CW'($urandom));
                cnt++;
                m = $urandom_range(1, 10);
                repeat (m)
                begin
                    queue_request(REQ_ADD, pick_coord(last_x), pick_coord(last_y));
                    cnt++;
                end
                if ($urandom_range(9) == 0)
                begin
                    queue_request(REQ_CLEAR, CW'($urandom), CW'($urandom));
                    cnt++;
                end
            end
            else
            begin
                queue_request(REQ_WIDTH'($urandom_range(3)), CW'($urandom), CW'($urandom));
                cnt++;
            end
        end
    endtask

    // Call on a rising edge; returns on the edge that completed the write.
    task automatic write_threshold(logic [THR_WIDTH-1:0] value);
        cfg_valid_q <= 1'b1;
        cfg_thr_q <= value;
        @(posedge clk);
        while (!cfg_bus.ready)
            @(posedge clk);
        cfg_valid_q <= 1'b0;
        dup_thr = value;
    endtask

    task automatic drain();
        do
            @(posedge clk);
        while (checked_cnt != issued_cnt);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_threshold(THR_RESET);
        phase = PH_FREE;
        queue_request(REQ_ADD, '0, '0);
        queue_request(REQ_RESERVED, COORD_MAX, COORD_MIN);
        queue_request(REQ_START, '0, '0);
        queue_request(REQ_ADD, COORD_MIN, COORD_MIN);
        queue_request(REQ_ADD, COORD_MIN, COORD_MIN);
        queue_request(REQ_ADD, COORD_MAX, COORD_MAX);
        queue_request(REQ_ADD, COORD_MAX, COORD_MIN);
        queue_request(REQ_ADD, '0, '0);
        // A new polygon adds no length for the jump from the old one.
        queue_request(REQ_START, '1, '1);
        queue_request(REQ_START, '0, '0);
        queue_request(REQ_ADD, '1, CW'(1));
        queue_request(REQ_ADD, CW'(1), '1);
        queue_request(REQ_ADD, CW'(1), '1);
        queue_request(REQ_ADD, CW'(2), '1);
        queue_request(REQ_RESERVED, CW'(5), CW'(6));
        queue_request(REQ_CLEAR, COORD_MIN, COORD_MAX);
        queue_request(REQ_ADD, CW'(7), CW'(7));
        queue_request(REQ_START, '0, '0);
        queue_request(REQ_ADD, CW'(32'h1234_5678), CW'(-32'sh0765_4321));
        queue_request(REQ_ADD, CW'(32'h1234_567B), CW'(-32'sh0765_431D));
        queue_request(REQ_ADD, COORD_MIN, COORD_MAX);
        queue_request(REQ_CLEAR, '0, '0);
        drain();

        write_threshold('0);
        phase = PH_SEND;
        load_random(350);
        drain();

        write_threshold(THR_MAX);
        phase = PH_RECV;
        load_random(350);
        drain();

        write_threshold(THR_WIDTH'(32'h0001_0000));
        phase = PH_BOTH;
        load_random(350);
        drain();

        write_threshold(THR_WIDTH'($urandom));
        phase = PH_FREE;
        load_random(350);
        drain();

        // Longest segments corner to corner, then check the total survives and clears.
        write_threshold(THR_RESET);
        phase = PH_FREE;
        queue_request(REQ_START, '0, '0);
        queue_request(REQ_ADD, COORD_MIN, COORD_MIN);
        queue_request(REQ_ADD, COORD_MAX, COORD_MAX);
        queue_request(REQ_ADD, COORD_MIN, COORD_MAX);
        queue_request(REQ_ADD, COORD_MAX, COORD_MIN);
        queue_request(REQ_ADD, COORD_MAX, COORD_MIN);
        queue_request(REQ_ADD, '0, '0);
        queue_request(REQ_RESERVED, '0, '0);
        queue_request(REQ_CLEAR, '0, '0);
        queue_request(REQ_START, '0, '0);
        queue_request(REQ_ADD, CW'(3), CW'(4));
        queue_request(REQ_ADD, '0, '0);
        drain();

        if (err_cnt == 0 && expected_results.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
